// File: src/htw_pkg.sv
// Shared constants for the hashed timing wheel: field widths, command kinds,
// result status codes. No dependencies.
package htw_pkg;

	localparam int KIND_W   = 2;
	localparam int DELAY_W  = 24;
	localparam int HANDLE_W = 32;
	localparam int TAG_W    = 32;
	localparam int STATUS_W = 3;
	localparam int TL_W     = 25;
	localparam int CNT_W    = 26;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;
	localparam logic [KIND_W-1:0] KIND_FIND   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
	localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd5;
	localparam logic [STATUS_W-1:0] ST_TICK_IDLE = 3'd6;

endpackage

// File: src/hashed_timing_wheel_scheduler_core.sv
// Hashed timing wheel scheduler: command sequencer, slot/entry memories and
// list walker. Depends on htw_pkg and htw_div (shared slot splitter).
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+----------------------------------------
//  command   | start, busy (accept: start & !busy) | kind, delay, handle, payload_tag
//  result    | result_strobe (1 cycle)     | status, timer_handle, ticks_rem, tag_out, last
//
// After reset a clearing pass over max(SLOTS, ENTRIES) addresses holds busy high.
// SLOTS is a power of two. Results leave a register the cycle after they are decided.
// Insert: busy while it splits the deadline, walks the slot list and links the entry;
//   a pool-full insert leaves busy low and answers on the next cycle.
// Cancel/find: walks the slot list node by node; a hit reckons ticks_rem, a cancel hit frees the node.
// Tick: busy while it expires due heads of the current and the next slot, one expired timer at a time.
// The receiver cannot stall; busy covers each command but a pool-full insert.
module hashed_timing_wheel_scheduler_core import htw_pkg::*; #(
	parameter int SLOTS   = 64,
	parameter int ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [KIND_W-1:0]   kind,
	input  logic [DELAY_W-1:0]  delay,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [TAG_W-1:0]    payload_tag,
	output logic                result_strobe,
	output logic [STATUS_W-1:0] status,
	output logic [HANDLE_W-1:0] timer_handle,
	output logic [TL_W-1:0]     ticks_rem,
	output logic [TAG_W-1:0]    tag_out,
	output logic                last
);

	localparam int SW     = $clog2(SLOTS);
	localparam int IW     = $clog2(ENTRIES);
	localparam int EW     = $clog2(ENTRIES + 1);
	localparam int DW     = $clog2(((1 << DELAY_W) - 1) / SLOTS + 1);
	localparam int INIT_N = (SLOTS > ENTRIES) ? SLOTS : ENTRIES;
	localparam int NW     = $clog2(INIT_N);
	localparam logic [EW-1:0] NOENT    = EW'(ENTRIES);
	localparam logic [SW-1:0] SLOT_MAX = SW'(SLOTS - 1);

	localparam logic [4:0] S_INIT   = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_I_DIV1 = 5'd2;
	localparam logic [4:0] S_I_DIV2 = 5'd3;
	localparam logic [4:0] S_I_HEAD = 5'd4;
	localparam logic [4:0] S_I_WRD  = 5'd5;
	localparam logic [4:0] S_I_WALK = 5'd6;
	localparam logic [4:0] S_I_LINK = 5'd7;
	localparam logic [4:0] S_I_FIN  = 5'd8;
	localparam logic [4:0] S_I_OUT  = 5'd9;
	localparam logic [4:0] S_X_RDH  = 5'd10;
	localparam logic [4:0] S_X_HEAD = 5'd11;
	localparam logic [4:0] S_X_ENT  = 5'd12;
	localparam logic [4:0] S_X_END  = 5'd13;
	localparam logic [4:0] S_C_DIV  = 5'd14;
	localparam logic [4:0] S_C_RDH  = 5'd15;
	localparam logic [4:0] S_C_HEAD = 5'd16;
	localparam logic [4:0] S_C_ENT  = 5'd17;
	localparam logic [4:0] S_C_TL   = 5'd18;
	localparam logic [4:0] S_C_TL2  = 5'd19;
	localparam logic [4:0] S_C_REL  = 5'd20;

	// memories
	logic [EW-1:0]       slot_head_mem [SLOTS];
	logic [DW-1:0]       delta_mem     [ENTRIES];
	logic [EW-1:0]       link_mem      [ENTRIES];
	logic [HANDLE_W-1:0] handle_mem    [ENTRIES];
	logic [TAG_W-1:0]    tag_mem       [ENTRIES];

	logic [EW-1:0]       sh_rd_q;
	logic [DW-1:0]       d_rd_q;
	logic [EW-1:0]       l_rd_q;
	logic [HANDLE_W-1:0] h_rd_q;
	logic [TAG_W-1:0]    t_rd_q;

	// control and working registers
	logic [4:0]          state_q;
	logic [NW-1:0]       init_q;
	logic [31:0]         now_q;
	logic [SW-1:0]       cslot_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [EW-1:0]       free_q;
	logic [KIND_W-1:0]   kind_q;
	logic [DELAY_W-1:0]  delay_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [TAG_W-1:0]    tag_q;
	logic [SW-1:0]       slot_q;
	logic [SW-1:0]       s_q;
	logic                phase_q;
	logic [DW-1:0]       rev_q;
	logic [IW-1:0]       e_q;
	logic [EW-1:0]       cur_q;
	logic [EW-1:0]       prev_q;
	logic [EW-1:0]       nx_q;
	logic [DW-1:0]       sum_q;
	logic [DW-1:0]       dcur_q;
	logic [31:0]         mul_q;
	logic                pend_v_q;
	logic [HANDLE_W-1:0] pend_h_q;
	logic [TAG_W-1:0]    pend_t_q;

	logic                out_v_q;
	logic [STATUS_W-1:0] out_st_q;
	logic [HANDLE_W-1:0] out_h_q;
	logic [TL_W-1:0]     out_tl_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic                out_last_q;

	// memory ports
	logic                sh_we;
	logic [SW-1:0]       sh_wa;
	logic [EW-1:0]       sh_wd;
	logic [SW-1:0]       sh_ra;
	logic                d_we;
	logic [IW-1:0]       d_wa;
	logic [DW-1:0]       d_wd;
	logic                l_we;
	logic [IW-1:0]       l_wa;
	logic [EW-1:0]       l_wd;
	logic                h_we;
	logic                t_we;
	logic [IW-1:0]       e_ra;
	logic [HANDLE_W-1:0] new_handle;

	// slot splitter
	logic                div_go;
	logic [HANDLE_W-1:0] div_val;
	logic                div_done;
	logic [HANDLE_W-1:0] div_quo;
	logic [SW-1:0]       div_rem;

	// result staging
	logic                emit;
	logic [STATUS_W-1:0] emit_st;
	logic [HANDLE_W-1:0] emit_h;
	logic [TL_W-1:0]     emit_tl;
	logic [TAG_W-1:0]    emit_tag;
	logic                emit_last;

	logic                accept;
	logic [SW-1:0]       cs_nxt;
	logic [SW:0]         tl_diff;
	logic [TL_W-1:0]     tl_c;
	logic [DW-1:0]       sum_nxt;
	logic                hit;

	htw_div #(.SLOTS(SLOTS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.value  (div_val),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	assign accept     = start && (state_q == S_IDLE);
	assign cs_nxt     = (now_q == 32'hFFFF_FFFF) ? '0 :
	                    ((cslot_q == SLOT_MAX) ? '0 : cslot_q + SW'(1));
	assign tl_diff    = {1'b0, slot_q} + ((slot_q < cslot_q) ? (SW+1)'(SLOTS) : '0)
	                    - {1'b0, cslot_q};
	assign tl_c       = mul_q[TL_W-1:0] + TL_W'(tl_diff);
	assign sum_nxt    = sum_q + d_rd_q;
	assign hit        = (h_rd_q == handle_q);
	assign new_handle = mul_q + 32'(slot_q);

	always_comb begin
		sh_we = 1'b0; sh_wa = slot_q; sh_wd = NOENT;
		d_we = 1'b0;  d_wa = cur_q[IW-1:0]; d_wd = '0;
		l_we = 1'b0;  l_wa = cur_q[IW-1:0]; l_wd = free_q;
		h_we = 1'b0;  t_we = 1'b0;
		e_ra = cur_q[IW-1:0];
		sh_ra = (state_q == S_X_RDH) ? s_q : slot_q;
		div_go = 1'b0; div_val = handle;
		emit = 1'b0; emit_st = ST_TICK_IDLE; emit_h = '0; emit_tl = '0; emit_tag = '0;
		emit_last = 1'b1;
		unique case (state_q)
			S_INIT: begin
				sh_we = ({1'b0, init_q} < (NW+1)'(SLOTS));
				sh_wa = SW'(init_q);
				l_we  = ({1'b0, init_q} < (NW+1)'(ENTRIES));
				l_wa  = IW'(init_q);
				l_wd  = EW'(init_q) + EW'(1);
			end
			S_IDLE: begin
				if (start && kind == KIND_INSERT) begin
					if (free_q >= NOENT) begin
						emit    = 1'b1;
						emit_st = ST_POOL_FULL;
					end else begin
						div_go  = 1'b1;
						div_val = now_q + 32'(delay);
					end
				end else if (start && (kind == KIND_CANCEL || kind == KIND_FIND)) begin
					div_go  = 1'b1;
					div_val = handle;
				end
			end
			S_I_DIV1: begin
				div_go  = div_done;
				div_val = 32'(delay_q);
			end
			S_I_DIV2: e_ra = free_q[IW-1:0];
			S_I_WALK: begin
				if (d_rd_q > rev_q) begin
					d_we = 1'b1;
					d_wd = d_rd_q - rev_q;
				end
			end
			S_I_LINK: begin
				d_we = 1'b1; d_wa = e_q; d_wd = rev_q;
				l_we = 1'b1; l_wa = e_q; l_wd = cur_q;
				t_we = 1'b1;
			end
			S_I_FIN: begin
				if (prev_q >= NOENT) begin
					sh_we = 1'b1;
					sh_wd = EW'(e_q);
				end else begin
					l_we = 1'b1;
					l_wa = prev_q[IW-1:0];
					l_wd = EW'(e_q);
				end
			end
			S_I_OUT: begin
				h_we    = 1'b1;
				emit    = 1'b1;
				emit_st = ST_INSERTED;
				emit_h  = new_handle;
			end
			S_X_HEAD: e_ra = sh_rd_q[IW-1:0];
			S_X_ENT: begin
				e_ra = l_rd_q[IW-1:0];
				if (d_rd_q == '0) begin
					// unlink head, push it onto the free list
					sh_we = 1'b1; sh_wa = s_q; sh_wd = l_rd_q;
					l_we  = 1'b1;
					if (pend_v_q) begin
						emit      = 1'b1;
						emit_st   = ST_EXPIRED;
						emit_h    = pend_h_q;
						emit_tag  = pend_t_q;
						emit_last = 1'b0;
					end
				end else if (!phase_q) begin
					d_we = 1'b1;
					d_wd = d_rd_q - DW'(1);
				end
			end
			S_X_END: begin
				if (phase_q) begin
					emit = 1'b1;
					if (pend_v_q) begin
						emit_st  = ST_EXPIRED;
						emit_h   = pend_h_q;
						emit_tag = pend_t_q;
					end
				end
			end
			S_C_HEAD: begin
				e_ra = sh_rd_q[IW-1:0];
				if (sh_rd_q >= NOENT) begin
					emit    = 1'b1;
					emit_st = ST_NOT_FOUND;
				end
			end
			S_C_ENT: begin
				e_ra = l_rd_q[IW-1:0];
				if (!hit && l_rd_q >= NOENT) begin
					emit    = 1'b1;
					emit_st = ST_NOT_FOUND;
				end
			end
			S_C_TL: e_ra = nx_q[IW-1:0];
			S_C_TL2: begin
				if (kind_q == KIND_FIND) begin
					emit    = 1'b1;
					emit_st = ST_FOUND;
					emit_h  = handle_q;
					emit_tl = tl_c;
				end else begin
					// fold the removed delta into the successor
					if (nx_q < NOENT) begin
						d_we = 1'b1;
						d_wa = nx_q[IW-1:0];
						d_wd = d_rd_q + dcur_q;
					end
					if (prev_q >= NOENT) begin
						sh_we = 1'b1;
						sh_wd = nx_q;
					end else begin
						l_we = 1'b1;
						l_wa = prev_q[IW-1:0];
						l_wd = nx_q;
					end
				end
			end
			S_C_REL: begin
				l_we    = 1'b1;
				emit    = 1'b1;
				emit_st = ST_CANCELLED;
				emit_h  = handle_q;
				emit_tl = tl_c;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (sh_we)
			slot_head_mem[sh_wa] <= sh_wd;
		sh_rd_q <= slot_head_mem[sh_ra];
	end

	always_ff @(posedge clk) begin
		if (d_we)
			delta_mem[d_wa] <= d_wd;
		d_rd_q <= delta_mem[e_ra];
	end

	always_ff @(posedge clk) begin
		if (l_we)
			link_mem[l_wa] <= l_wd;
		l_rd_q <= link_mem[e_ra];
	end

	always_ff @(posedge clk) begin
		if (h_we)
			handle_mem[e_q] <= new_handle;
		h_rd_q <= handle_mem[e_ra];
	end

	always_ff @(posedge clk) begin
		if (t_we)
			tag_mem[e_q] <= tag_q;
		t_rd_q <= tag_mem[e_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			init_q   <= '0;
			now_q    <= '0;
			cslot_q  <= '0;
			cnt_q    <= '0;
			free_q   <= '0;
			kind_q   <= KIND_INSERT;
			delay_q  <= '0;
			handle_q <= '0;
			tag_q    <= '0;
			slot_q   <= '0;
			s_q      <= '0;
			phase_q  <= 1'b0;
			rev_q    <= '0;
			e_q      <= '0;
			cur_q    <= NOENT;
			prev_q   <= NOENT;
			nx_q     <= NOENT;
			sum_q    <= '0;
			dcur_q   <= '0;
			mul_q    <= '0;
			pend_v_q <= 1'b0;
			pend_h_q <= '0;
			pend_t_q <= '0;
			out_v_q  <= 1'b0;
			out_st_q <= ST_TICK_IDLE;
			out_h_q  <= '0;
			out_tl_q <= '0;
			out_tag_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			out_v_q <= emit;
			if (emit) begin
				out_st_q   <= emit_st;
				out_h_q    <= emit_h;
				out_tl_q   <= emit_tl;
				out_tag_q  <= emit_tag;
				out_last_q <= emit_last;
			end
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + NW'(1);
					if (init_q == NW'(INIT_N - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						kind_q   <= kind;
						delay_q  <= delay;
						handle_q <= handle;
						tag_q    <= payload_tag;
						case (kind)
							KIND_INSERT: begin
								if (free_q < NOENT)
									state_q <= S_I_DIV1;
							end
							KIND_TICK: begin
								s_q      <= cslot_q;
								phase_q  <= 1'b0;
								pend_v_q <= 1'b0;
								state_q  <= S_X_RDH;
							end
							default: state_q <= S_C_DIV;
						endcase
					end
				end
				S_I_DIV1: begin
					if (div_done) begin
						slot_q  <= div_rem;
						state_q <= S_I_DIV2;
					end
				end
				S_I_DIV2: begin
					if (div_done) begin
						rev_q   <= div_quo[DW-1:0];
						e_q     <= free_q[IW-1:0];
						state_q <= S_I_HEAD;
					end
				end
				S_I_HEAD: begin
					free_q  <= l_rd_q;
					cur_q   <= sh_rd_q;
					prev_q  <= NOENT;
					state_q <= S_I_WRD;
				end
				S_I_WRD: state_q <= (cur_q >= NOENT) ? S_I_LINK : S_I_WALK;
				S_I_WALK: begin
					if (d_rd_q > rev_q) begin
						state_q <= S_I_LINK;
					end else begin
						rev_q   <= rev_q - d_rd_q;
						prev_q  <= cur_q;
						cur_q   <= l_rd_q;
						state_q <= S_I_WRD;
					end
				end
				S_I_LINK: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_I_FIN;
				end
				S_I_FIN: begin
					mul_q   <= 32'(cnt_q) << SW;
					state_q <= S_I_OUT;
				end
				S_I_OUT: state_q <= S_IDLE;
				S_X_RDH: state_q <= S_X_HEAD;
				S_X_HEAD: begin
					cur_q   <= sh_rd_q;
					state_q <= (sh_rd_q >= NOENT) ? S_X_END : S_X_ENT;
				end
				S_X_ENT: begin
					if (d_rd_q == '0) begin
						free_q   <= cur_q;
						pend_v_q <= 1'b1;
						pend_h_q <= h_rd_q;
						pend_t_q <= t_rd_q;
						cur_q    <= l_rd_q;
						if (l_rd_q >= NOENT)
							state_q <= S_X_END;
					end else begin
						state_q <= S_X_END;
					end
				end
				S_X_END: begin
					if (!phase_q) begin
						now_q   <= now_q + 32'd1;
						cslot_q <= cs_nxt;
						s_q     <= cs_nxt;
						phase_q <= 1'b1;
						state_q <= S_X_RDH;
					end else begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				S_C_DIV: begin
					if (div_done) begin
						slot_q  <= div_rem;
						state_q <= S_C_RDH;
					end
				end
				S_C_RDH: state_q <= S_C_HEAD;
				S_C_HEAD: begin
					cur_q   <= sh_rd_q;
					prev_q  <= NOENT;
					sum_q   <= '0;
					state_q <= (sh_rd_q >= NOENT) ? S_IDLE : S_C_ENT;
				end
				S_C_ENT: begin
					sum_q <= sum_nxt;
					if (hit) begin
						nx_q    <= l_rd_q;
						dcur_q  <= d_rd_q;
						state_q <= S_C_TL;
					end else begin
						prev_q <= cur_q;
						cur_q  <= l_rd_q;
						if (l_rd_q >= NOENT)
							state_q <= S_IDLE;
					end
				end
				S_C_TL: begin
					mul_q   <= 32'(sum_q) << SW;
					state_q <= S_C_TL2;
				end
				S_C_TL2: state_q <= (kind_q == KIND_FIND) ? S_IDLE : S_C_REL;
				S_C_REL: begin
					free_q  <= cur_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign result_strobe = out_v_q;
	assign status        = out_st_q;
	assign timer_handle  = out_h_q;
	assign ticks_rem     = out_tl_q;
	assign tag_out       = out_tag_q;
	assign last          = out_last_q;

`ifndef SYNTHESIS
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= NOENT) else $error("free list head out of range");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cslot_q} < (SW+1)'(SLOTS)) else $error("current slot out of range");
	a_mid_expiry: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last) |-> (status == ST_EXPIRED))
		else $error("non-final result that is not an expiry");
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_TICK) |=> busy) else $error("tick not taken");
`endif

endmodule

// File: src/htw_div.sv
// Slot splitter for a power-of-two slot count: revolutions by shift, slot
// index by mask; done follows go in the next cycle. Uses htw_pkg.
module htw_div import htw_pkg::*; #(
	parameter int SLOTS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [HANDLE_W-1:0]   value,
	output logic                  done,
	output logic [HANDLE_W-1:0]   quo,
	output logic [$clog2(SLOTS)-1:0] rem
);

	localparam int SW = $clog2(SLOTS);

	logic                done_q;
	logic [HANDLE_W-1:0] quo_q;
	logic [SW-1:0]       rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			quo_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= go;
			if (go) begin
				quo_q <= value >> SW;
				rem_q <= value[SW-1:0];
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

`ifndef SYNTHESIS
	a_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		(SLOTS & (SLOTS - 1)) == 0) else $error("slot count not a power of two");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> done_q) else $error("split result not ready after go");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ({1'b0, rem_q} < (SW+1)'(SLOTS))) else $error("remainder out of range");
`endif

endmodule
